/* rtl/core/mlp_pkg.sv */
`default_nettype none
package mlp_pkg;

  localparam int unsigned N_MAX   = 4;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 15;
  localparam int unsigned WGT_W   = 12;
  localparam int unsigned BIAS_W  = 16;
  localparam int unsigned BIAS_LSB = 48;
  localparam int unsigned FRAC_SH = 10;
  localparam int unsigned PROD_W  = WGT_W + IN_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned SHR_W   = SUM_W - FRAC_SH;
  localparam int unsigned RES_W   = SHR_W + 1;
  localparam int unsigned REG_W   = 64;
  localparam int unsigned REG_CNT = 2 * N_MAX;
  localparam int unsigned IDX_W   = $clog2(REG_CNT);
  localparam int unsigned ADDR_LSB = 3;
  localparam int unsigned ADDR_W  = IDX_W + ADDR_LSB;

  typedef logic [REG_W-1:0] nreg_t;
  typedef logic [N_MAX-1:0][REG_W-1:0] layer_regs_t;
  typedef logic [N_MAX-1:0][IN_W-1:0] xvec_t;
  typedef logic [N_MAX-1:0][OUT_W-1:0] yvec_t;

  function automatic logic signed [WGT_W-1:0] get_weight(input nreg_t r,
                                                         input int unsigned j);
    get_weight = $signed(r[WGT_W*j +: WGT_W]);
  endfunction

  function automatic logic signed [BIAS_W-1:0] get_bias(input nreg_t r);
    get_bias = $signed(r[BIAS_LSB +: BIAS_W]);
  endfunction

  // clamp negatives to zero, saturate positives to 15 bits unsigned
  function automatic logic [OUT_W-1:0] sat_relu(input logic signed [RES_W-1:0] v);
    logic [OUT_W-1:0] res;
    res = v[OUT_W-1:0];
    if (v[RES_W-1]) begin
      res = '0;
    end else if (|v[RES_W-2:OUT_W]) begin
      res = '1;
    end
    sat_relu = res;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mlp_ifs.sv */
`default_nettype none
interface mlp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mlp_pkg::IN_W-1:0]    in_a;
  logic signed [mlp_pkg::IN_W-1:0]    in_b;
  logic signed [mlp_pkg::IN_W-1:0]    in_c;
  logic signed [mlp_pkg::IN_W-1:0]    in_d;
  modport source (output valid, in_a, in_b, in_c, in_d, input ready);
  modport sink (input valid, in_a, in_b, in_c, in_d, output ready);
endinterface

interface mlp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mlp_pkg::OUT_W-1:0]   out_a;
  logic [mlp_pkg::OUT_W-1:0]   out_b;
  logic [mlp_pkg::OUT_W-1:0]   out_c;
  logic [mlp_pkg::OUT_W-1:0]   out_d;
  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface
`default_nettype wire

/* rtl/core/mlp_cfg.sv */
`default_nettype none
module mlp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mlp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mlp_pkg::REG_W-1:0]   pwdata,
  output logic      [mlp_pkg::REG_W-1:0]   prdata,
  output logic                             pready,
  output mlp_pkg::layer_regs_t             hid_regs,
  output mlp_pkg::layer_regs_t             out_regs
);
  import mlp_pkg::*;

  nreg_t regs_r [REG_CNT];
  logic [IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = regs_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_CNT; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      regs_r[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < N_MAX; i++) begin
      hid_regs[i] = regs_r[i];
      out_regs[i] = regs_r[N_MAX + i];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/mlp_layer.sv */
`default_nettype none
module mlp_layer #(
  parameter int unsigned NEURONS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mlp_pkg::layer_regs_t  regs,
  input  wire logic                  x_valid,
  output logic                       x_ready,
  input  wire mlp_pkg::xvec_t        x,
  output logic                       y_valid,
  input  wire logic                  y_ready,
  output mlp_pkg::yvec_t             y
);
  import mlp_pkg::*;

  logic signed [PROD_W-1:0] prod_r [NEURONS][NEURONS];
  logic prod_valid_r;
  logic prod_ready;
  logic res_ready;
  yvec_t y_r;
  yvec_t y_nxt;
  logic y_valid_r;

  assign res_ready  = !y_valid_r || y_ready;
  assign prod_ready = !prod_valid_r || res_ready;
  assign x_ready    = prod_ready;
  assign y_valid    = y_valid_r;
  assign y          = y_r;

  // stage 1: weight times input products
  always_ff @(posedge clk) begin
    if (prod_ready && x_valid) begin
      for (int i = 0; i < NEURONS; i++) begin
        for (int j = 0; j < NEURONS; j++) begin
          prod_r[i][j] <= PROD_W'(get_weight(regs[i], j)) * PROD_W'($signed(x[j]));
        end
      end
    end
  end

  // stage 2: sum, scale, bias, saturate, relu
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [RES_W-1:0] r;
    y_nxt = '0;
    for (int i = 0; i < NEURONS; i++) begin
      acc = '0;
      for (int j = 0; j < NEURONS; j++) begin
        acc = acc + SUM_W'(prod_r[i][j]);
      end
      r = RES_W'($signed(acc[SUM_W-1:FRAC_SH])) + RES_W'(get_bias(regs[i]));
      y_nxt[i] = sat_relu(r);
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && prod_valid_r) begin
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      y_valid_r    <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= x_valid;
      end
      if (res_ready) begin
        y_valid_r <= prod_valid_r;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/two_layer_relu_mlp_4x4.sv */
// pipeline: four register stages, two per layer
// throughput: one input vector per cycle while the result side is ready, set by one multiplier per weight in each layer
// stalls on the result side hold every stage in place without loss
// reset: synchronous active-low rst_n clears pipeline valids and all neuron registers to 0
`default_nettype none
module two_layer_relu_mlp_4x4 #(
  parameter int unsigned NEURONS = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mlp_in_if.sink                           in_ch,
  mlp_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mlp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mlp_pkg::REG_W-1:0]   pwdata,
  output logic      [mlp_pkg::REG_W-1:0]   prdata,
  output logic                             pready
);
  import mlp_pkg::*;

  layer_regs_t hid_regs;
  layer_regs_t out_regs;
  xvec_t x_vec;
  xvec_t h_vec;
  yvec_t h_y;
  yvec_t o_y;
  logic h_valid;
  logic h_ready;

  mlp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .hid_regs (hid_regs),
    .out_regs (out_regs)
  );

  assign x_vec[0] = in_ch.in_a;
  assign x_vec[1] = in_ch.in_b;
  assign x_vec[2] = in_ch.in_c;
  assign x_vec[3] = in_ch.in_d;

  mlp_layer #(.NEURONS(NEURONS)) u_hidden (
    .clk     (clk),
    .rst_n   (rst_n),
    .regs    (hid_regs),
    .x_valid (in_ch.valid),
    .x_ready (in_ch.ready),
    .x       (x_vec),
    .y_valid (h_valid),
    .y_ready (h_ready),
    .y       (h_y)
  );

  always_comb begin
    for (int i = 0; i < N_MAX; i++) begin
      h_vec[i] = {1'b0, h_y[i]};
    end
  end

  mlp_layer #(.NEURONS(NEURONS)) u_output (
    .clk     (clk),
    .rst_n   (rst_n),
    .regs    (out_regs),
    .x_valid (h_valid),
    .x_ready (h_ready),
    .x       (h_vec),
    .y_valid (out_ch.valid),
    .y_ready (out_ch.ready),
    .y       (o_y)
  );

  assign out_ch.out_a = o_y[0];
  assign out_ch.out_b = o_y[1];
  assign out_ch.out_c = o_y[2];
  assign out_ch.out_d = o_y[3];
endmodule
`default_nettype wire

/* sim/two_layer_relu_mlp_4x4_test.sv */
`default_nettype none
module two_layer_relu_mlp_4x4_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mlp_pkg::*;

  localparam int HIDDEN_BASE = 0;
  localparam int OUTPUT_BASE = N_MAX;
  localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1 << FRAC_SH);
  localparam int OUT_MAX = (1 << OUT_W) - 1;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 120;

  typedef enum int {NET_FULL, NET_MODERATE, NET_GENTLE} net_kind_e;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  nreg_t pwdata;
  nreg_t prdata;
  logic pready;

  mlp_in_if in_ch ();
  mlp_out_if out_ch ();

  nreg_t neuron_regs [REG_CNT];
  yvec_t expected_outputs [$];
  int mismatches = 0;
  int vectors_sent = 0;
  int outputs_checked = 0;
  int reg_writes = 0;
  int networks_loaded = 0;
  int idle_pct = 0;
  int hold_off_len = 0;

  two_layer_relu_mlp_4x4 u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int fire_neuron(input nreg_t r, input int x [N_MAX]);
    longint acc;
    longint sum;
    int j;
    acc = 0;
    for (j = 0; j < N_MAX; j++) begin
      acc += longint'($signed(r[WGT_W*j +: WGT_W])) * x[j];
    end
    sum = (acc >>> FRAC_SH) + longint'($signed(r[BIAS_LSB +: BIAS_W]));
    if (sum > OUT_MAX) begin
      sum = OUT_MAX;
    end
    if (sum < 0) begin
      sum = 0;
    end
    return int'(sum);
  endfunction

  function automatic yvec_t predict_outputs(input xvec_t x);
    int xs [N_MAX];
    int hs [N_MAX];
    yvec_t y;
    int i;
    for (i = 0; i < N_MAX; i++) begin
      xs[i] = int'($signed(x[i]));
    end
    for (i = 0; i < N_MAX; i++) begin
      hs[i] = fire_neuron(neuron_regs[HIDDEN_BASE + i], xs);
    end
    for (i = 0; i < N_MAX; i++) begin
      y[i] = OUT_W'(fire_neuron(neuron_regs[OUTPUT_BASE + i], hs));
    end
    return y;
  endfunction

  function automatic nreg_t pack_neuron(input logic [BIAS_W-1:0] bias,
                                        input logic [WGT_W-1:0] w0, w1, w2, w3);
    return {bias, w3, w2, w1, w0};
  endfunction

  function automatic nreg_t unit_neuron(input int pos, input logic [WGT_W-1:0] w,
                                        input logic [BIAS_W-1:0] bias);
    nreg_t r;
    r = '0;
    r[WGT_W*pos +: WGT_W] = w;
    r[BIAS_LSB +: BIAS_W] = bias;
    return r;
  endfunction

  function automatic nreg_t random_neuron(input net_kind_e kind);
    logic [WGT_W-1:0] w [N_MAX];
    logic [BIAS_W-1:0] bias;
    int wspan;
    int bspan;
    int j;
    if (kind == NET_FULL) begin
      return {$urandom, $urandom};
    end
    wspan = (kind == NET_MODERATE) ? 1024 : 256;
    bspan = (kind == NET_MODERATE) ? 16384 : 4096;
    for (j = 0; j < N_MAX; j++) begin
      w[j] = WGT_W'($urandom_range(0, wspan - 1) - wspan / 2);
    end
    bias = BIAS_W'($urandom_range(0, bspan - 1) - bspan / 2);
    return pack_neuron(bias, w[0], w[1], w[2], w[3]);
  endfunction

  function automatic logic [IN_W-1:0] random_input();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3, 4: return IN_W'($urandom_range(0, 8191) - 4096);
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic xvec_t random_vector();
    xvec_t x;
    int i;
    for (i = 0; i < N_MAX; i++) begin
      x[i] = random_input();
    end
    return x;
  endfunction

  function automatic xvec_t make_vector(input logic [IN_W-1:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  task automatic send_vector(input xvec_t x);
    yvec_t y;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    y = predict_outputs(x);
    in_ch.valid <= 1'b1;
    in_ch.in_a <= x[0];
    in_ch.in_b <= x[1];
    in_ch.in_c <= x[2];
    in_ch.in_d <= x[3];
    do @(posedge clk); while (!in_ch.ready);
    expected_outputs.push_back(y);
    vectors_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_outputs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_neuron(input int idx, input nreg_t value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx << ADDR_LSB);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    neuron_regs[idx] = value;
    reg_writes++;
    @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, value, prdata);
      mismatches++;
    end
  endtask

  task automatic load_network(input nreg_t net [REG_CNT]);
    int i;
    drain();
    for (i = 0; i < REG_CNT; i++) begin
      write_neuron(i, net[i]);
    end
    networks_loaded++;
  endtask

  task automatic load_random_network(input net_kind_e kind);
    nreg_t net [REG_CNT];
    int i;
    for (i = 0; i < REG_CNT; i++) begin
      net[i] = random_neuron(kind);
    end
    load_network(net);
  endtask

  task automatic load_uniform_network(input nreg_t value);
    nreg_t net [REG_CNT];
    int i;
    for (i = 0; i < REG_CNT; i++) begin
      net[i] = value;
    end
    load_network(net);
  endtask

  task automatic check_result();
    string names [N_MAX] = '{"out_a", "out_b", "out_c", "out_d"};
    yvec_t want;
    yvec_t got;
    int i;
    got = {out_ch.out_d, out_ch.out_c, out_ch.out_b, out_ch.out_a};
    if (expected_outputs.size() == 0) begin
      $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
               $time, got[0], got[1], got[2], got[3]);
      mismatches++;
    end else begin
      want = expected_outputs.pop_front();
      outputs_checked++;
      for (i = 0; i < N_MAX; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: %s expected %0d actual %0d", $time, names[i], want[i], got[i]);
          mismatches++;
        end
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_result();
      end
    end
  end

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
        out_ch.ready <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_state();
    idle_pct = 0;
    send_vector(make_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vector(random_vector());
  endtask

  // neuron 3 of the hidden layer exercises floor rounding of the shift
  task automatic test_identity_and_rounding();
    nreg_t net [REG_CNT];
    int i;
    for (i = 0; i < N_MAX; i++) begin
      net[HIDDEN_BASE + i] = unit_neuron(i, WEIGHT_ONE, '0);
      net[OUTPUT_BASE + i] = unit_neuron(i, WEIGHT_ONE, '0);
    end
    net[HIDDEN_BASE + N_MAX - 1] = unit_neuron(N_MAX - 1, WGT_W'(1), BIAS_W'(1));
    load_network(net);
    send_vector(make_vector(16'h7fff, 16'h8000, 16'h0001, 16'hffff));
    send_vector(make_vector(16'h8000, 16'h7fff, 16'hffff, 16'h03ff));
    send_vector(make_vector(16'h0001, 16'h0000, 16'h7fff, 16'h0400));
    send_vector(make_vector(16'hffff, 16'h0001, 16'h8000, 16'hfc00));
    send_vector(make_vector(16'h1000, 16'hf000, 16'h0800, 16'hfbff));
    send_vector(make_vector(16'h0000, 16'h0000, 16'h0000, 16'h7fff));
    send_vector(make_vector(16'h0000, 16'h0000, 16'h0000, 16'h8000));
    send_vector(make_vector(16'h5555, 16'haaaa, 16'h1234, 16'hedcb));
  endtask

  task automatic test_saturation();
    load_uniform_network(pack_neuron(16'h7fff, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff));
    send_vector(make_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vector(make_vector(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    load_uniform_network(pack_neuron(16'h8000, 12'h800, 12'h800, 12'h800, 12'h800));
    send_vector(make_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_vector(make_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vector(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    load_uniform_network('1);
    send_vector(make_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_vector(make_vector(16'h8000, 16'h8000, 16'h8000, 16'h8000));
  endtask

  task automatic test_random_networks();
    int pcts [6] = '{20, 40, 0, 30, 60, 10};
    net_kind_e kinds [3] = '{NET_FULL, NET_MODERATE, NET_GENTLE};
    int p;
    int n;
    for (p = 0; p < 6; p++) begin
      idle_pct = 0;
      load_random_network(kinds[p % 3]);
      idle_pct = pcts[p];
      for (n = 0; n < 200; n++) begin
        send_vector(random_vector());
      end
    end
  endtask

  task automatic test_backpressure();
    int n;
    idle_pct = 0;
    load_random_network(NET_MODERATE);
    hold_off_len = HOLD_OFF_CYCLES;
    for (n = 0; n < 60; n++) begin
      send_vector(random_vector());
    end
  endtask

  task automatic test_streaming();
    int n;
    idle_pct = 0;
    load_random_network(NET_GENTLE);
    for (n = 0; n < 270; n++) begin
      send_vector(random_vector());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_a = '0;
    in_ch.in_b = '0;
    in_ch.in_c = '0;
    in_ch.in_d = '0;
    for (int i = 0; i < REG_CNT; i++) begin
      neuron_regs[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_identity_and_rounding();
    test_saturation();
    test_random_networks();
    test_backpressure();
    test_streaming();
    drain();

    $display("covered %0d input vectors over %0d weight sets (%0d register writes),",
             vectors_sent, networks_loaded, reg_writes);
    $display("including saturation, rounding, a long output stall and a gap-free stream");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
